// ===== sv/fm_index_search_locate_unit_macros.svh =====
// Assertion macros shared by the FM-index search and locate unit.
`ifndef FM_INDEX_SEARCH_LOCATE_UNIT_MACROS_SVH
`define FM_INDEX_SEARCH_LOCATE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FMI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fm index check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FMI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fm index check failed");

`endif

// ===== sv/fmi_pkg.sv =====
// Package with types, constants and codes of the FM-index search and locate unit.
`timescale 1ns / 1ps
package fmi_pkg;

  localparam int TEXT_LEN = 1024;
  localparam int ALPHABET = 16;
  localparam int ADDR_W   = $clog2(TEXT_LEN);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int SYM_W    = 4;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_LOCATE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] STAT_LOADED  = 3'd0;
  localparam logic [2:0] STAT_RANGE   = 3'd1;
  localparam logic [2:0] STAT_NOMATCH = 3'd2;
  localparam logic [2:0] STAT_FOUND   = 3'd3;
  localparam logic [2:0] STAT_REJECT  = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  symbol;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] suffix_pos;
    logic [ADDR_W-1:0] row;
  } fmi_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CNT_W-1:0]  range_low;
    logic [CNT_W-1:0]  range_high;
    logic [CNT_W-1:0]  match_count;
    logic [ADDR_W-1:0] text_position;
  } fmi_out_t;

  typedef logic [ALPHABET-1:0][CNT_W-1:0] fmi_occ_row_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } fmi_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic divisible;
  } fmi_div_stat_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LD_DIV,
    FSM_SR_LO,
    FSM_SR_HI,
    FSM_LC_CHK,
    FSM_WAIT
  } fmi_state_t;

endpackage

// ===== sv/fm_index_search_locate_unit.sv =====
// Top level of the FM-index engine: BWT load, backward search and locate.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid / in_stall / in_item carries load, search and locate
//   commands; output channel out_valid / out_stall / out_item returns exactly one
//   result item per input item. cfg_we / cfg_data write sample_rate (0 acts as 1).
//   The unit takes one item at a time; in_stall is high while an item is at work.
// Work per item, from acceptance to the result entering the output register:
//   load   : bit-serial remainder over 10 suffix bits, then one row write.
//   search : two dependent reads of the occurrence memory, one port.
//   locate : S LF steps to a sampled row (one dependent read of the
//            BWT, sample and occurrence memories per step, S <= sample_rate-1
//            for a consistent load), or LF steps until the walk gives up.
//   A rejected load, an unknown command, a search that fails at once and an
//   out-of-range row go straight to waiting for the output register.
// Reset clears the counts, the C offsets, the text length and the search range;
//   the memories keep their contents and hold valid data only for loaded rows.
// While the receiver stalls the output register holds its item; the unit still
//   takes one more item and parks its result until the output register frees.
module fm_index_search_locate_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fmi_pkg::fmi_in_t     in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fmi_pkg::fmi_out_t    out_item,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_data
);
  import fmi_pkg::*;

  // Memories: one row per loaded BWT position.
  logic [SYM_W-1:0] bwt_mem [TEXT_LEN];
  logic [CNT_W-1:0] smp_mem [TEXT_LEN];
  fmi_occ_row_t     occ_mem [TEXT_LEN];

  logic [SYM_W-1:0] bwt_q;
  logic [CNT_W-1:0] smp_q;
  fmi_occ_row_t     occ_q;

  // Control state.
  fmi_state_t       state, state_next;
  logic [CNT_W-1:0] sample_rate;
  logic [CNT_W-1:0] tot   [ALPHABET];
  logic [CNT_W-1:0] c_off [ALPHABET];
  logic [CNT_W-1:0] text_length;
  logic [CNT_W-1:0] search_low;
  logic [CNT_W-1:0] search_high;
  logic             search_failed;

  // Working registers.
  fmi_in_t          it;
  logic [ADDR_W-1:0] pos;
  logic [CNT_W-1:0] steps;
  logic [CNT_W-1:0] occ_lo;
  fmi_out_t         res;
  fmi_out_t         res_init;

  fmi_div_req_t     div_req;
  fmi_div_stat_t    div_stat;

  logic             accept;
  logic             slot_free;
  logic [CNT_W-1:0] ld_tl;
  logic             ld_drop;
  logic [CNT_W-1:0] low_e, high_e;
  logic             sr_fail_now;
  logic             lc_bad;
  logic [CNT_W-1:0] rate_eff;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W:0]   newpos;
  logic             lc_hit, lc_timeout, lc_lost, lc_end;
  logic [CNT_W-1:0] occ_hi;
  logic [CNT_W-1:0] sr_lo, sr_hi;
  logic             mem_we;
  fmi_occ_row_t     occ_wr;

  fmi_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  // Decode of the item at the input.
  assign accept      = in_valid && (state == FSM_IDLE);
  assign slot_free   = !out_valid || !out_stall;
  assign ld_tl       = in_item.first ? '0 : text_length;
  assign ld_drop     = ld_tl >= CNT_W'(TEXT_LEN);
  assign low_e       = in_item.first ? '0 : search_low;
  assign high_e      = in_item.first ? text_length : search_high;
  // A 4-bit symbol always lies inside the alphabet; absent means a zero total.
  assign sr_fail_now = (!in_item.first && search_failed) || (tot[in_item.symbol] == '0);
  assign lc_bad      = {1'b0, in_item.row} >= text_length;
  assign rate_eff    = (sample_rate == '0) ? CNT_W'(1) : sample_rate;

  // Result an accepted item starts from: searches default to no match.
  always_comb begin
    res_init        = '0;
    res_init.status = (in_item.cmd == CMD_SEARCH) ? STAT_NOMATCH : STAT_REJECT;
  end

  // One LF step: C offset plus running count, minus one.
  assign newpos     = {1'b0, c_off[bwt_q]} + {1'b0, occ_q[bwt_q]} - (CNT_W+1)'(1);
  assign lc_hit     = smp_q[ADDR_W];
  assign lc_timeout = steps >= CNT_W'(TEXT_LEN);
  assign lc_lost    = newpos >= {1'b0, text_length};
  assign lc_end     = lc_hit || lc_timeout || lc_lost;

  // Backward search bounds.
  assign occ_hi = (search_high != '0) ? occ_q[it.symbol] : '0;
  assign sr_lo  = c_off[it.symbol] + occ_lo;
  assign sr_hi  = c_off[it.symbol] + occ_hi;

  // Row written at each stored load: totals with this symbol counted.
  always_comb begin
    for (int k = 0; k < ALPHABET; k++) begin
      occ_wr[k] = tot[k] + ((SYM_W'(k) == it.symbol) ? CNT_W'(1) : CNT_W'(0));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          case (in_item.cmd)
            CMD_LOAD:   state_next = ld_drop ? FSM_WAIT : FSM_LD_DIV;
            CMD_SEARCH: state_next = sr_fail_now ? FSM_WAIT : FSM_SR_LO;
            CMD_LOCATE: state_next = lc_bad ? FSM_WAIT : FSM_LC_CHK;
            default:    state_next = FSM_WAIT;
          endcase
        end
      end
      FSM_LD_DIV: if (div_stat.done) state_next = FSM_WAIT;
      FSM_SR_LO:  state_next = FSM_SR_HI;
      FSM_SR_HI:  state_next = FSM_WAIT;
      FSM_LC_CHK: if (lc_end) state_next = FSM_WAIT;
      FSM_WAIT:   if (slot_free) state_next = FSM_IDLE;
      default:    state_next = FSM_IDLE;
    endcase
  end

  // Outputs: handshake, memory address, divider start, write strobe.
  always_comb begin
    in_stall         = (state != FSM_IDLE);
    mem_we           = (state == FSM_LD_DIV) && div_stat.done;
    div_req.start    = accept && (in_item.cmd == CMD_LOAD) && !ld_drop;
    div_req.dividend = in_item.suffix_pos;
    div_req.divisor  = rate_eff;
    case (state)
      FSM_IDLE:   rd_addr = (in_item.cmd == CMD_SEARCH) ? ADDR_W'(low_e - 1'b1)
                                                        : in_item.row;
      FSM_SR_LO:  rd_addr = ADDR_W'(search_high - 1'b1);
      FSM_LC_CHK: rd_addr = newpos[ADDR_W-1:0];
      default:    rd_addr = pos;
    endcase
  end

  // Memories: one write and one read address per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bwt_mem[text_length[ADDR_W-1:0]] <= it.symbol;
      smp_mem[text_length[ADDR_W-1:0]] <= div_stat.divisible ? {1'b1, it.suffix_pos} : '0;
      occ_mem[text_length[ADDR_W-1:0]] <= occ_wr;
    end
    bwt_q <= bwt_mem[rd_addr];
    smp_q <= smp_mem[rd_addr];
    occ_q <= occ_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FSM_IDLE;
      sample_rate   <= CNT_W'(32);
      text_length   <= '0;
      search_low    <= '0;
      search_high   <= '0;
      search_failed <= 1'b0;
      out_valid     <= 1'b0;
      for (int k = 0; k < ALPHABET; k++) begin
        tot[k]   <= '0;
        c_off[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) sample_rate <= cfg_data;

      if (accept) begin
        case (in_item.cmd)
          CMD_LOAD: begin
            // A new load forgets the old counts even when the row is dropped.
            if (in_item.first) begin
              text_length <= '0;
              for (int k = 0; k < ALPHABET; k++) begin
                tot[k]   <= '0;
                c_off[k] <= '0;
              end
            end
          end
          CMD_SEARCH: begin
            search_low  <= low_e;
            search_high <= high_e;
            if (sr_fail_now) search_failed <= 1'b1;
            else             search_failed <= 1'b0;
          end
          default: ;
        endcase
      end

      if (mem_we) begin
        for (int k = 0; k < ALPHABET; k++) begin
          tot[k] <= occ_wr[k];
          if (SYM_W'(k) > it.symbol) c_off[k] <= c_off[k] + 1'b1;
        end
        text_length   <= text_length + 1'b1;
        search_low    <= '0;
        search_high   <= text_length + 1'b1;
        search_failed <= 1'b0;
      end

      if (state == FSM_SR_HI) begin
        search_low  <= sr_lo;
        search_high <= sr_hi;
        if (sr_lo >= sr_hi) search_failed <= 1'b1;
      end

      // Move the parked result into the output register when it frees.
      if (state == FSM_WAIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      it    <= in_item;
      pos   <= in_item.row;
      steps <= '0;
      res   <= res_init;
    end
    if (state == FSM_SR_LO) begin
      occ_lo <= (search_low != '0) ? occ_q[it.symbol] : '0;
    end
    if (mem_we) begin
      res.status     <= STAT_LOADED;
      res.range_high <= text_length + 1'b1;
    end
    if (state == FSM_SR_HI) begin
      if (sr_lo >= sr_hi) begin
        res.status <= STAT_NOMATCH;
      end else begin
        res.status      <= STAT_RANGE;
        res.range_low   <= sr_lo;
        res.range_high  <= sr_hi;
        res.match_count <= sr_hi - sr_lo;
      end
    end
    if (state == FSM_LC_CHK) begin
      if (lc_hit) begin
        res.status        <= STAT_FOUND;
        res.text_position <= smp_q[ADDR_W-1:0] + steps[ADDR_W-1:0];
      end else if (lc_end) begin
        res.status <= STAT_NOMATCH;
      end else begin
        // Advance one LF step.
        pos   <= newpos[ADDR_W-1:0];
        steps <= steps + 1'b1;
      end
    end
    if (state == FSM_WAIT && slot_free) out_item <= res;
  end

`include "fm_index_search_locate_unit_macros.svh"

  `FMI_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != FSM_IDLE)
  `FMI_ASSERT_NEXT(a_wait_holds, clk, rst, state == FSM_WAIT && out_valid && out_stall, state == FSM_WAIT)
  `FMI_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, text_length <= CNT_W'(TEXT_LEN))
  `FMI_ASSERT_NOW(a_write_in_div, clk, rst, mem_we, state == FSM_LD_DIV && !div_stat.busy)

endmodule

// ===== sv/fmi_mod_unit.sv =====
// Bit-serial remainder unit: tells whether a suffix position divides by the sample rate.
`timescale 1ns / 1ps
module fmi_mod_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  fmi_pkg::fmi_div_req_t req,
  output fmi_pkg::fmi_div_stat_t stat
);
  import fmi_pkg::*;

  logic [CNT_W-1:0]         rem;
  logic [ADDR_W-1:0]        quo;
  logic [CNT_W-1:0]         divisor;
  logic [$clog2(ADDR_W):0]  cnt;
  logic                     busy;
  logic                     done;
  logic [CNT_W:0]           trial;

  // Shift in one dividend bit, subtract the divisor where it fits.
  assign trial = {rem, quo[ADDR_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= ($clog2(ADDR_W)+1)'(ADDR_W);
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        quo <= {quo[ADDR_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= CNT_W'(trial - {1'b0, divisor});
        end else begin
          rem <= CNT_W'(trial);
        end
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(ADDR_W)+1)'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy      = busy;
  assign stat.done      = done;
  assign stat.divisible = (rem == '0);

endmodule
